// ===== design/plcm_pkg.sv =====
// Shared constants and types of the piecewise linear colormap core.
package plcm_pkg;

  localparam int NUM_STOPS  = 7;
  localparam int POS_W      = 17;
  localparam int CHAN_W     = 8;
  localparam int RGB_W      = 3 * CHAN_W;
  localparam int STOP_W     = POS_W + RGB_W;
  localparam int FRAC_W     = 16;
  localparam int DIV_STAGES = FRAC_W;
  localparam int LEVEL_W    = 16;
  localparam int ZQ_W       = 16;
  localparam int CNT_W      = 3;
  localparam int SEL_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int T_W        = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_FIRST = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LAST  = 4'd7;

  localparam logic [CNT_W-1:0]  STOP_COUNT_RST = 3'd2;
  localparam logic [CNT_W-1:0]  STOP_COUNT_MIN = 3'd2;
  localparam logic [STOP_W-1:0] STOP0_RST      = 41'h000_00FF_FFFF;
  localparam logic [STOP_W-1:0] STOP1_RST      = 41'h100_0000_0000;

  typedef logic [STOP_W-1:0] stop_t;
  typedef stop_t [NUM_STOPS-1:0] stop_arr_t;

  // Sideband that travels with each word through the divider
  typedef struct packed {
    logic [RGB_W-1:0] left_rgb;
    logic [RGB_W-1:0] right_rgb;
    logic             frac_zero;
    logic             frac_one;
  } plcm_side_t;

endpackage

// ===== design/piecewise_linear_colormap_core.sv =====
// Top level of the piecewise linear colormap core.
//
// Input: raise start with a signed Q.12 level on in_level; a word is taken at
// each rising edge where start is high and busy is low. busy stays low, so a
// new level may be taken every cycle.
// Output: out_valid is high for one cycle with out_red, out_green, out_blue;
// the receiver must take the word in that cycle. Results come out in input
// order, one per cycle at most. The pipeline is the 16-stage fraction
// divider (one quotient bit per stage), two front stages (quantize, segment
// search) and two blend stages.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always
// high. Index 0 is the stop count, indexes 1 to 7 are stops 0 to 6; other
// indexes are ignored. Write only while no level is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// map: two stops, white at position 0 and black at position 65536.
// The receiver cannot stall, so the pipeline never holds.
module piecewise_linear_colormap_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [plcm_pkg::LEVEL_W-1:0] in_level,
  output logic                                out_valid,
  output logic [plcm_pkg::CHAN_W-1:0]         out_red,
  output logic [plcm_pkg::CHAN_W-1:0]         out_green,
  output logic [plcm_pkg::CHAN_W-1:0]         out_blue,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plcm_pkg::STOP_W-1:0]         cfg_data
);
  import plcm_pkg::*;

  logic             in_take;
  logic [CNT_W-1:0] stop_count_r;
  stop_arr_t        stops_r;

  logic             seg_valid;
  logic [POS_W-1:0] div_num, div_den;
  plcm_side_t       seg_side;

  logic              q_valid;
  logic [FRAC_W-1:0] q_quot;
  plcm_side_t        q_side;

  logic             mix_valid;
  logic [RGB_W-1:0] mix_rgb;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_take   = start && !busy;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= STOP_COUNT_RST;
      stops_r[0] <= STOP0_RST;
      stops_r[1] <= STOP1_RST;
      for (int i = 2; i < NUM_STOPS; i++) begin
        stops_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STOP_COUNT) begin
        stop_count_r <= cfg_data[CNT_W-1:0];
      end else if (cfg_index >= REG_STOP_FIRST && cfg_index <= REG_STOP_LAST) begin
        stops_r[SEL_W'(cfg_index - REG_STOP_FIRST)] <= cfg_data;
      end
    end
  end

  plcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_level   (in_level),
    .stop_count (stop_count_r),
    .stops      (stops_r),
    .seg_valid  (seg_valid),
    .div_num    (div_num),
    .div_den    (div_den),
    .seg_side   (seg_side)
  );

  plcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (seg_valid),
    .in_num   (div_num),
    .in_den   (div_den),
    .in_side  (seg_side),
    .q_valid  (q_valid),
    .q_quot   (q_quot),
    .q_side   (q_side)
  );

  plcm_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_quot    (q_quot),
    .q_side    (q_side),
    .mix_valid (mix_valid),
    .mix_rgb   (mix_rgb)
  );

  assign out_valid = mix_valid;
  assign out_red   = mix_rgb[2*CHAN_W +: CHAN_W];
  assign out_green = mix_rgb[CHAN_W +: CHAN_W];
  assign out_blue  = mix_rgb[0 +: CHAN_W];

  // Every accepted level yields an output word
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##20 out_valid)
    else $error("accepted level produced no result at the expected cycle");

  // A fraction cannot be forced to both ends at once
  a_frac_flags : assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid |-> !(seg_side.frac_zero && seg_side.frac_one))
    else $error("fraction forced to zero and to one together");

  // The divider sees a numerator below the divisor when it must divide
  a_div_range : assert property (@(posedge clk) disable iff (!rst_n)
    (seg_valid && !seg_side.frac_zero && !seg_side.frac_one) |-> (div_num < div_den))
    else $error("divider operand out of range");

endmodule

// ===== design/plcm_front.sv =====
// Front end: level quantization, segment search and divider operands.
module plcm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  logic signed [plcm_pkg::LEVEL_W-1:0] in_level,
  input  logic [plcm_pkg::CNT_W-1:0]    stop_count,
  input  plcm_pkg::stop_arr_t           stops,
  output logic                          seg_valid,
  output logic [plcm_pkg::POS_W-1:0]    div_num,
  output logic [plcm_pkg::POS_W-1:0]    div_den,
  output plcm_pkg::plcm_side_t          seg_side
);
  import plcm_pkg::*;

  logic            a_valid_r;
  logic [ZQ_W-1:0] a_zq_r;
  logic [ZQ_W-1:0] a_zq_nxt;
  logic [10:0]     bin_raw;
  logic [7:0]      bin;

  logic                 b_valid_r;
  logic [POS_W-1:0]     b_num_r, b_num_nxt;
  logic [POS_W-1:0]     b_den_r, b_den_nxt;
  plcm_side_t           b_side_r, b_side_nxt;

  logic [CNT_W-1:0] cnt;
  logic [SEL_W-1:0] left;
  logic [SEL_W-1:0] right;
  logic [POS_W-1:0] pos [NUM_STOPS];
  logic [POS_W-1:0] pl, pr, zq_e;
  logic             fzero;

  // Clamp negatives, quantize to a bin, take the bin start point
  always_comb begin
    bin_raw = in_level[LEVEL_W-1] ? 11'd0 : in_level[14:4];
    bin     = (|bin_raw[10:8]) ? 8'hFF : bin_raw[7:0];
    a_zq_nxt = {bin, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_take;
    end
    a_zq_r <= a_zq_nxt;
  end

  // Pick the first segment that holds the point
  always_comb begin
    cnt = (stop_count < STOP_COUNT_MIN) ? STOP_COUNT_MIN : stop_count;
    for (int i = 0; i < NUM_STOPS; i++) begin
      pos[i] = stops[i][STOP_W-1:RGB_W];
    end
    zq_e = {1'b0, a_zq_r};
    left = '0;
    for (int i = NUM_STOPS - 2; i >= 0; i--) begin
      if ((CNT_W'(i + 1) < cnt) && (zq_e >= pos[i]) && (zq_e <= pos[i+1])) begin
        left = SEL_W'(i);
      end
    end
    right = left + 1'b1;
    pl = pos[left];
    pr = pos[right];
    fzero = !(pr > pl) || (zq_e <= pl);
    b_num_nxt = zq_e - pl;
    b_den_nxt = pr - pl;
    b_side_nxt.left_rgb  = stops[left][RGB_W-1:0];
    b_side_nxt.right_rgb = stops[right][RGB_W-1:0];
    b_side_nxt.frac_zero = fzero;
    b_side_nxt.frac_one  = !fzero && (zq_e >= pr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_num_r  <= b_num_nxt;
    b_den_r  <= b_den_nxt;
    b_side_r <= b_side_nxt;
  end

  assign seg_valid = b_valid_r;
  assign div_num   = b_num_r;
  assign div_den   = b_den_r;
  assign seg_side  = b_side_r;

endmodule

// ===== design/plcm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module plcm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [plcm_pkg::POS_W-1:0]   in_num,
  input  logic [plcm_pkg::POS_W-1:0]   in_den,
  input  plcm_pkg::plcm_side_t         in_side,
  output logic                         q_valid,
  output logic [plcm_pkg::FRAC_W-1:0]  q_quot,
  output plcm_pkg::plcm_side_t         q_side
);
  import plcm_pkg::*;

  logic              v_r    [DIV_STAGES];
  logic [POS_W-1:0]  rem_r  [DIV_STAGES];
  logic [POS_W-1:0]  den_r  [DIV_STAGES];
  logic [FRAC_W-1:0] quot_r [DIV_STAGES];
  plcm_side_t        side_r [DIV_STAGES];

  logic [POS_W-1:0]  rem_src  [DIV_STAGES];
  logic [POS_W-1:0]  den_src  [DIV_STAGES];
  logic [FRAC_W-1:0] quot_src [DIV_STAGES];
  logic [POS_W:0]    shl      [DIV_STAGES];
  logic [POS_W-1:0]  rem_nxt  [DIV_STAGES];
  logic [FRAC_W-1:0] quot_nxt [DIV_STAGES];

  // Shift, trial subtract, keep the quotient bit
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_src[k]  = (k == 0) ? in_num : rem_r[(k == 0) ? 0 : k-1];
      den_src[k]  = (k == 0) ? in_den : den_r[(k == 0) ? 0 : k-1];
      quot_src[k] = (k == 0) ? '0     : quot_r[(k == 0) ? 0 : k-1];
      shl[k] = {rem_src[k], 1'b0};
      if (shl[k] >= {1'b0, den_src[k]}) begin
        rem_nxt[k]  = POS_W'(shl[k] - {1'b0, den_src[k]});
        quot_nxt[k] = {quot_src[k][FRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = shl[k][POS_W-1:0];
        quot_nxt[k] = {quot_src[k][FRAC_W-2:0], 1'b0};
      end
    end
  end

  // Advance every stage each cycle
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
      rem_r[k]  <= rem_nxt[k];
      den_r[k]  <= den_src[k];
      quot_r[k] <= quot_nxt[k];
      side_r[k] <= (k == 0) ? in_side : side_r[(k == 0) ? 0 : k-1];
    end
  end

  assign q_valid = v_r[DIV_STAGES-1];
  assign q_quot  = quot_r[DIV_STAGES-1];
  assign q_side  = side_r[DIV_STAGES-1];

endmodule

// ===== design/plcm_mix.sv =====
// Channel interpolation and 16-to-8 bit rounding.
module plcm_mix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [plcm_pkg::FRAC_W-1:0]  q_quot,
  input  plcm_pkg::plcm_side_t         q_side,
  output logic                         mix_valid,
  output logic [plcm_pkg::RGB_W-1:0]   mix_rgb
);
  import plcm_pkg::*;

  logic              t_valid_r;
  logic [T_W-1:0]    t_r   [3];
  logic [T_W-1:0]    t_nxt [3];
  logic [FRAC_W:0]   frac;
  logic [CHAN_W-1:0] ca, cb;
  logic signed [CHAN_W:0]   diff;
  logic signed [26:0]       prod, tsum;

  logic              o_valid_r;
  logic [RGB_W-1:0]  o_rgb_r, o_rgb_nxt;
  logic [31:0]       scaled;

  // Blend each channel: a * 65536 + (b - a) * f
  always_comb begin
    frac = q_side.frac_one  ? {1'b1, {FRAC_W{1'b0}}} :
           q_side.frac_zero ? '0 : {1'b0, q_quot};
    for (int c = 0; c < 3; c++) begin
      ca   = q_side.left_rgb[c*CHAN_W +: CHAN_W];
      cb   = q_side.right_rgb[c*CHAN_W +: CHAN_W];
      diff = $signed({1'b0, cb}) - $signed({1'b0, ca});
      prod = 27'(diff * $signed({1'b0, frac}));
      tsum = $signed({3'b000, ca, 16'h0000}) + prod;
      t_nxt[c] = tsum[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else begin
      t_valid_r <= q_valid;
    end
    for (int c = 0; c < 3; c++) begin
      t_r[c] <= t_nxt[c];
    end
  end

  // Scale by 257, round, keep the top byte
  always_comb begin
    o_rgb_nxt = '0;
    scaled    = '0;
    for (int c = 0; c < 3; c++) begin
      scaled = {8'h00, t_r[c]} + {t_r[c], 8'h00} + 32'h0000_8000;
      o_rgb_nxt[c*CHAN_W +: CHAN_W] = scaled[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= t_valid_r;
    end
    o_rgb_r <= o_rgb_nxt;
  end

  assign mix_valid = o_valid_r;
  assign mix_rgb   = o_rgb_r;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the piecewise linear colormap core.
`timescale 1ns / 100ps

module testbench;
  import plcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 4'd15;
  localparam logic [STOP_W-1:0]    STOP_ALL_ONES   = {STOP_W{1'b1}};
  localparam int                   PIPE_LATENCY    = 20;
  localparam int                   RAND_PHASES     = 8;
  localparam int                   PHASE_WORDS     = 75;
  localparam int                   DUE_DEPTH       = 64;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // One row of the directed part: a register write or a level
  typedef struct packed {
    logic                       is_cfg;
    logic [CFG_IDX_W-1:0]       idx;
    logic [STOP_W-1:0]          data;
    logic signed [LEVEL_W-1:0]  lvl;
    logic                       has_exp;
    logic [RGB_W-1:0]           exp_rgb;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [LEVEL_W-1:0]  in_level;
  logic                       out_valid;
  logic [CHAN_W-1:0]          out_red;
  logic [CHAN_W-1:0]          out_green;
  logic [CHAN_W-1:0]          out_blue;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [STOP_W-1:0]          cfg_data;

  // Shadow copy of the map registers
  logic [CNT_W-1:0]  map_count;
  logic [STOP_W-1:0] map_stops [NUM_STOPS];

  // Ring of expected colors: written at due_tail, read at due_head
  rgb_t colors_due [DUE_DEPTH];
  int   due_head;
  int   due_tail;
  int   fail_count;

  piecewise_linear_colormap_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_level  (in_level),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [STOP_W-1:0] stop_word(input logic [POS_W-1:0] pos,
                                                  input logic [RGB_W-1:0] rgb);
    return {pos, rgb};
  endfunction

  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input longint frac);
    longint t;
    longint c16;
    t = longint'(a) * 65536 + (longint'(b) - longint'(a)) * frac;
    if (t < 0) t = 0;
    c16 = (257 * t + 32768) >>> 16;
    return c16[15:8];
  endfunction

  // Quantize the level, pick the segment and interpolate the stop colors
  function automatic rgb_t shade(input logic signed [LEVEL_W-1:0] lvl);
    longint lv, bin, zq, pl, pr, frac;
    int     cnt, seg;
    bit     found;
    rgb_t   res;
    lv  = lvl[LEVEL_W-1] ? 0 : longint'(lvl);
    bin = (lv * 256) >>> 12;
    if (bin > 255) bin = 255;
    zq  = bin * 256;
    cnt = int'(map_count);
    if (cnt < 2) cnt = 2;
    if (cnt > NUM_STOPS) cnt = NUM_STOPS;
    seg   = 0;
    found = 1'b0;
    for (int i = 0; i + 1 < cnt; i++) begin
      if (!found && zq >= longint'(map_stops[i][STOP_W-1:RGB_W]) &&
          zq <= longint'(map_stops[i+1][STOP_W-1:RGB_W])) begin
        seg   = i;
        found = 1'b1;
      end
    end
    pl   = longint'(map_stops[seg][STOP_W-1:RGB_W]);
    pr   = longint'(map_stops[seg+1][STOP_W-1:RGB_W]);
    frac = 0;
    if (pr > pl) begin
      if (zq <= pl) frac = 0;
      else if (zq - pl >= pr - pl) frac = 65536;
      else frac = ((zq - pl) * 65536) / (pr - pl);
    end
    res.red   = blend_chan(map_stops[seg][23:16], map_stops[seg+1][23:16], frac);
    res.green = blend_chan(map_stops[seg][15:8], map_stops[seg+1][15:8], frac);
    res.blue  = blend_chan(map_stops[seg][7:0], map_stops[seg+1][7:0], frac);
    return res;
  endfunction

  function automatic void report_mismatch(input rgb_t exp_c, input rgb_t got_c);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at %0t: expected %h %h %h, got %h %h %h", $realtime,
               exp_c.red, exp_c.green, exp_c.blue, got_c.red, got_c.green, got_c.blue);
  endfunction

  // Append one expected color to the ring
  function automatic void note_due(input rgb_t c);
    colors_due[due_tail % DUE_DEPTH] = c;
    due_tail++;
  endfunction

  // Compare each output word with the oldest expected color
  always @(posedge clk) begin
    rgb_t got_c;
    rgb_t exp_c;
    if (rst_n && out_valid) begin
      got_c = '{out_red, out_green, out_blue};
      if (due_tail == due_head) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word at %0t: %h %h %h", $realtime,
                   out_red, out_green, out_blue);
      end else begin
        exp_c = colors_due[due_head % DUE_DEPTH];
        due_head++;
        if (got_c !== exp_c) report_mismatch(exp_c, got_c);
      end
    end
  end

  // Present a level and hold it until taken; start stays high on return
  task automatic send_level(input logic signed [LEVEL_W-1:0] lvl, input bit has_exp,
                            input logic [RGB_W-1:0] exp_rgb);
    rgb_t pred;
    @(negedge clk);
    start    <= 1'b1;
    in_level <= lvl;
    do @(posedge clk); while (busy);
    pred = shade(lvl);
    if (has_exp && pred !== rgb_t'(exp_rgb)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("predictor disagrees for level %h: %h", lvl, pred);
    end
    note_due(has_exp ? rgb_t'(exp_rgb) : pred);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop start and wait until every expected word has come out
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (due_tail != due_head) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_STOP_COUNT) map_count = data[CNT_W-1:0];
    else if (idx >= REG_STOP_FIRST && idx <= REG_STOP_LAST)
      map_stops[SEL_W'(idx - REG_STOP_FIRST)] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load a random map: mostly ascending stops, sometimes raw words
  task automatic random_map(input int ph);
    logic [STOP_W-1:0] w;
    int pos;
    int mode;
    mode = $urandom_range(0, 4);
    write_reg(REG_STOP_COUNT,
              STOP_W'((ph == 0) ? 7 : (ph == 1) ? 0 : $urandom_range(0, 7)));
    pos = 0;
    for (int k = 0; k < NUM_STOPS; k++) begin
      if (mode == 0) begin
        w = STOP_W'({$urandom, $urandom});
      end else if (mode == 1 && k == 6) begin
        w = (ph % 2) ? STOP_ALL_ONES : '0;
      end else begin
        w = stop_word(POS_W'(pos), RGB_W'($urandom));
        pos = (k == NUM_STOPS - 2 || $urandom_range(0, 5) == 0) ? 65536 :
              pos + $urandom_range(0, 20000);
        if (pos > 65536) pos = 65536;
      end
      write_reg(CFG_IDX_W'(REG_STOP_FIRST + k), w);
    end
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'(REG_UNUSED_LOW + $urandom_range(0, 7)),
                STOP_W'({$urandom, $urandom}));
  endtask

  dir_row_t dir_rows [26] = '{
    '{1'b0, REG_STOP_COUNT, '0, 16'sd0,      1'b1, 24'hFFFFFF},
    '{1'b0, REG_STOP_COUNT, '0, 16'sh8000,   1'b1, 24'hFFFFFF},
    '{1'b0, REG_STOP_COUNT, '0, -16'sd1,     1'b1, 24'hFFFFFF},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd32767,  1'b1, 24'h010101},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd4096,   1'b1, 24'h010101},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd2048,   1'b0, 24'h0},
    '{1'b1, REG_UNUSED_LOW, STOP_ALL_ONES, 16'sd0, 1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd2048,   1'b0, 24'h0},
    '{1'b1, REG_UNUSED_HIGH, '0, 16'sd0,     1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd1,      1'b0, 24'h0},
    '{1'b1, REG_STOP_COUNT, '0, 16'sd0,      1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd3000,   1'b0, 24'h0},
    '{1'b1, REG_STOP_COUNT, 41'd1, 16'sd0,   1'b0, 24'h0},
    '{1'b1, REG_STOP_FIRST, {17'd10000, 24'hFF0000}, 16'sd0, 1'b0, 24'h0},
    '{1'b1, REG_STOP_FIRST + 4'd1, {17'd20480, 24'h0000FF}, 16'sd0, 1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd0,      1'b1, 24'hFF0000},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd4095,   1'b1, 24'h0000FF},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd1500,   1'b0, 24'h0},
    '{1'b1, REG_STOP_COUNT, 41'd7, 16'sd0,   1'b0, 24'h0},
    '{1'b1, REG_STOP_FIRST + 4'd2, {17'd20480, 24'h00FF00}, 16'sd0, 1'b0, 24'h0},
    '{1'b1, REG_STOP_FIRST + 4'd3, {17'd15000, 24'h808080}, 16'sd0, 1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd4095,   1'b0, 24'h0},
    '{1'b1, REG_STOP_FIRST, {17'd20480, 24'hFF0000}, 16'sd0, 1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd1280,   1'b1, 24'hFF0000},
    '{1'b1, REG_STOP_FIRST, STOP_ALL_ONES, 16'sd0, 1'b0, 24'h0},
    '{1'b0, REG_STOP_COUNT, '0, 16'sd0,      1'b0, 24'h0}
  };

  initial begin
    int idle_pct [4];
    logic signed [LEVEL_W-1:0] lvl;
    idle_pct   = '{0, 47, 19, 47};
    fail_count = 0;
    due_head   = 0;
    due_tail   = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_level   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    map_count  = STOP_COUNT_RST;
    for (int k = 0; k < NUM_STOPS; k++) map_stops[k] = '0;
    map_stops[0] = STOP0_RST;
    map_stops[1] = STOP1_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows; registers change only once drained
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        drain();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_level(dir_rows[r].lvl, dir_rows[r].has_exp, dir_rows[r].exp_rgb);
      end
    end

    // Random phases, each with a fresh map and an idle rate picked by phase from a four-entry table
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      random_map(ph);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < idle_pct[ph % 4])
          idle_cycles($urandom_range(1, 4));
        if ($urandom_range(0, 9) < 7) lvl = LEVEL_W'($urandom_range(0, 4095));
        else lvl = LEVEL_W'($urandom);
        send_level(lvl, 1'b0, '0);
      end
    end

    drain();
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && due_tail == due_head) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
